// ----- rtl/mee_pkg.sv -----
// Shared types and constants for the modular exponentiation engine.
package mee_pkg;

	localparam int OPERAND_BITS_DEF = 31;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_MODULUS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PUBLIC_EXP = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRIVATE_EXP = 2'd2;

	localparam logic KIND_ENCRYPT = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_PREP_W,
		ST_MUL,
		ST_MUL_W,
		ST_SQR,
		ST_SQR_W,
		ST_FINISH
	} mee_state_t;

endpackage

// ----- rtl/mee_mulmod.sv -----
// Bit-serial modular multiplier: one multiplier bit per cycle, most significant first.
module mee_mulmod
	import mee_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [OPERAND_BITS-1:0] a,
	input  logic [OPERAND_BITS-1:0] b,
	input  logic [OPERAND_BITS-1:0] n,
	output logic                    done,
	output logic [OPERAND_BITS-1:0] product
);

	localparam int W = OPERAND_BITS;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [W-1:0]  n_q;
	logic [W-1:0]  r_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   dbl;
	logic [W:0]   red1;
	logic [W:0]   sum;
	logic [W:0]   red2;
	logic [W-1:0] addend;

	always_comb begin
		dbl = {r_q, 1'b0};
		red1 = (dbl >= {1'b0, n_q}) ? (dbl - {1'b0, n_q}) : dbl;
		addend = a_q[W-1] ? b_q : '0;
		sum = {1'b0, red1[W-1:0]} + {1'b0, addend};
		red2 = (sum >= {1'b0, n_q}) ? (sum - {1'b0, n_q}) : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			a_q <= a;
			b_q <= b;
			n_q <= n;
			r_q <= '0;
		end else if (busy_q) begin
			a_q <= {a_q[W-2:0], 1'b0};
			r_q <= red2[W-1:0];
		end
	end

	assign done = done_q;
	assign product = r_q;

endmodule

// ----- rtl/modular_exponentiation_engine.sv -----
// Top level of the modular exponentiation engine with its sequencer and registers.
// Each accepted word is raised to the public exponent (kind encrypt) or the private
// exponent (kind decrypt) modulo the configured modulus, by right-to-left square and
// multiply. All arithmetic goes through one bit-serial modular multiplier. An item
// takes one reduction of the operand, then per exponent bit up to its highest set
// bit a square and, where the bit is set, a multiply; when the modulus is zero it
// skips all of these and goes straight to the result. The input stalls while an
// item is in work; the result waits in an output register, so a new word is taken
// as soon as the previous one has moved into it. The configuration port is always
// ready and should only be written while the engine is idle.
module modular_exponentiation_engine
	import mee_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [OPERAND_BITS-1:0]   operand_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [OPERAND_BITS-1:0]   result_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [OPERAND_BITS-1:0]   cfg_data
);

	localparam int W = OPERAND_BITS;

	mee_state_t state_q;
	mee_state_t state_d;

	logic [W-1:0] modulus_q;
	logic [W-1:0] pub_exp_q;
	logic [W-1:0] priv_exp_q;
	logic [W-1:0] n_q;
	logic [W-1:0] op_q;
	logic [W-1:0] exp_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] sq_q;
	logic [W-1:0] result_q;
	logic         out_valid_q;

	logic         mm_start;
	logic [W-1:0] mm_a;
	logic [W-1:0] mm_b;
	logic         mm_done;
	logic [W-1:0] mm_product;
	logic         out_load;

	mee_mulmod #(
		.OPERAND_BITS(OPERAND_BITS)
	) u_mulmod (
		.clk(clk),
		.arst_n(arst_n),
		.start(mm_start),
		.a(mm_a),
		.b(mm_b),
		.n(n_q),
		.done(mm_done),
		.product(mm_product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= W'(1);
			pub_exp_q <= W'(1);
			priv_exp_q <= W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_PUBLIC_EXP: pub_exp_q <= cfg_data;
				REG_PRIVATE_EXP: priv_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		mm_start = 1'b0;
		mm_a = sq_q;
		mm_b = sq_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (modulus_q == '0) ? ST_FINISH : ST_PREP;
				end
			end
			ST_PREP: begin
				mm_start = 1'b1;
				mm_a = op_q;
				mm_b = acc_q;
				state_d = ST_PREP_W;
			end
			ST_PREP_W: begin
				if (mm_done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (exp_q == '0) begin
					state_d = ST_FINISH;
				end else if (exp_q[0]) begin
					mm_start = 1'b1;
					mm_a = acc_q;
					mm_b = sq_q;
					state_d = ST_MUL_W;
				end else begin
					state_d = ST_SQR;
				end
			end
			ST_MUL_W: begin
				if (mm_done) begin
					state_d = ST_SQR;
				end
			end
			ST_SQR: begin
				mm_start = 1'b1;
				state_d = ST_SQR_W;
			end
			ST_SQR_W: begin
				if (mm_done) begin
					state_d = ST_MUL;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_q <= modulus_q;
					op_q <= operand_value;
					exp_q <= (kind == KIND_ENCRYPT) ? pub_exp_q : priv_exp_q;
					acc_q <= (modulus_q == '0 || modulus_q == W'(1)) ? '0 : W'(1);
				end
			end
			ST_PREP_W: begin
				if (mm_done) begin
					sq_q <= mm_product;
				end
			end
			ST_MUL_W: begin
				if (mm_done) begin
					acc_q <= mm_product;
				end
			end
			ST_SQR_W: begin
				if (mm_done) begin
					sq_q <= mm_product;
					exp_q <= exp_q >> 1;
				end
			end
			default: ;
		endcase
		if (out_load) begin
			result_q <= acc_q;
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign result_value = result_q;
	assign cfg_ready = 1'b1;

endmodule

// ----- rtl/mee_checker.sv -----
// Port-level assertions for the modular exponentiation engine and their binding.
module mee_checker
	import mee_pkg::*;
#(
	parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [OPERAND_BITS-1:0] result_value,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	// A waiting result word holds its value until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("result word changed while stalled");

	// After a word is taken the engine is busy in the cycle that follows.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again without a busy cycle");

	// A new result cannot appear in the cycle right after an input was accepted.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

	// The configuration port never refuses a write.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind modular_exponentiation_engine mee_checker #(
	.OPERAND_BITS(OPERAND_BITS)
) u_mee_checker (.*);
